### hw/rtl/dks_pkg.sv
package dks_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int KEY_W     = 32;
    localparam int HANDLE_W  = 16;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [HANDLE_W-1:0]     handle;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

endpackage

### hw/rtl/depth_key_sorter.sv
// Loading: one word accepted per cycle while o_stall is low, inserted in sorted place
// by a chain of cells. The word carrying batch_end closes the batch; the drain then pops
// the head cell into the output register, and one result follows per unstalled cycle.
// The input is stalled for the whole drain, until the last item is popped.
// Synchronous active-low reset empties every cell and clears the overflow flag.
module depth_key_sorter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [dks_pkg::KEY_W-1:0]    i_depth_key,
    input  logic [dks_pkg::HANDLE_W-1:0]        i_item_handle,
    input  logic                                i_batch_end,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [dks_pkg::KEY_W-1:0]    o_sorted_key,
    output logic [dks_pkg::HANDLE_W-1:0]        o_sorted_handle,
    output logic                                o_run_last,
    output logic                                o_overflowed
);
    import dks_pkg::*;

    typedef enum logic {ST_LOAD, ST_DRAIN} t_state;

    t_state    r_state;
    logic      r_ovf;
    logic      r_out_valid;
    t_entry    r_out;
    logic      r_out_last;
    logic      r_out_ovf;

    t_entry    w_new;
    t_cell_ctl w_ctl;
    t_entry    w_entry   [MAX_ITEMS];
    logic      w_valid   [MAX_ITEMS];
    logic      w_greater [MAX_ITEMS];

    logic      w_accept;
    logic      w_full;
    logic      w_pop;
    logic      w_pop_last;

    assign w_new.key    = i_depth_key;
    assign w_new.handle = i_item_handle;

    assign o_stall    = (r_state == ST_DRAIN);
    assign w_accept   = i_valid && !o_stall;
    assign w_full     = w_valid[MAX_ITEMS-1];
    assign w_pop      = (r_state == ST_DRAIN) && w_valid[0] && (!r_out_valid || !i_stall);
    assign w_pop_last = w_pop && !w_valid[1];

    assign w_ctl.insert = w_accept && !w_full;
    assign w_ctl.shift  = w_pop;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        t_entry w_left;
        logic   w_left_valid;
        logic   w_left_greater;
        t_entry w_right;
        logic   w_right_valid;

        if (g == 0) begin : g_head
            assign w_left         = w_new;
            assign w_left_valid   = 1'b0;
            assign w_left_greater = 1'b0;
        end else begin : g_mid
            assign w_left         = w_entry[g-1];
            assign w_left_valid   = w_valid[g-1];
            assign w_left_greater = w_greater[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign w_right       = w_new;
            assign w_right_valid = 1'b0;
        end else begin : g_body
            assign w_right       = w_entry[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        dks_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_ctl),
            .i_new          (w_new),
            .i_left         (w_left),
            .i_left_valid   (w_left_valid),
            .i_left_greater (w_left_greater),
            .i_right        (w_right),
            .i_right_valid  (w_right_valid),
            .o_entry        (w_entry[g]),
            .o_valid        (w_valid[g]),
            .o_greater      (w_greater[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (w_accept) begin
                        if (w_full) begin
                            r_ovf <= 1'b1;
                        end
                        if (i_batch_end) begin
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (w_pop_last) begin
                        r_state <= ST_LOAD;
                        r_ovf   <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
            if (w_pop) begin
                r_out_valid <= 1'b1;
                r_out       <= w_entry[0];
                r_out_last  <= !w_valid[1];
                r_out_ovf   <= r_ovf;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sorted_key    = r_out.key;
    assign o_sorted_handle = r_out.handle;
    assign o_run_last      = r_out_last;
    assign o_overflowed    = r_out_ovf;

endmodule

### hw/rtl/dks_cell.sv
module dks_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dks_pkg::t_cell_ctl i_ctl,
    input  dks_pkg::t_entry i_new,
    input  dks_pkg::t_entry i_left,
    input  logic            i_left_valid,
    input  logic            i_left_greater,
    input  dks_pkg::t_entry i_right,
    input  logic            i_right_valid,
    output dks_pkg::t_entry o_entry,
    output logic            o_valid,
    output logic            o_greater
);
    import dks_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   r_valid;
    logic   n_valid;

    // empty cells rank above every key; equal keys stay put so arrival order holds
    assign o_greater = !r_valid || (r_entry.key > i_new.key);

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctl.shift) begin
            n_entry = i_right;
            n_valid = i_right_valid;
        end else if (i_ctl.insert && o_greater) begin
            if (i_left_greater) begin
                n_entry = i_left;
                n_valid = i_left_valid;
            end else begin
                n_entry = i_new;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule

### hw/rtl/dks_checker.sv
module dks_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                i_batch_end,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [dks_pkg::KEY_W-1:0]    o_sorted_key,
    input logic [dks_pkg::HANDLE_W-1:0]        o_sorted_handle,
    input logic                                o_run_last,
    input logic                                o_overflowed
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sorted_key)
            && $stable(o_sorted_handle) && $stable(o_run_last) && $stable(o_overflowed))
        else $error("stalled output word changed");

    a_close_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_batch_end |=> o_stall)
        else $error("input not stalled after batch close");

    a_mid_run_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_run_last |-> o_stall)
        else $error("input open while a run is still draining");

    a_release_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_stall) && $past(i_rst_n) |-> o_valid && o_run_last)
        else $error("input released without final word");

endmodule

bind depth_key_sorter dks_checker u_dks_checker (.*);
